FILE: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_TEMP       = 3'd0,
		REG_CAL_PRESS_A    = 3'd1,
		REG_CAL_PRESS_B    = 3'd2,
		REG_CAL_PRESS_LAST = 3'd3,
		REG_CAL_HUM_A      = 3'd4,
		REG_CAL_HUM_B      = 3'd5
	} reg_idx_t;

	// calibration words, each extended to a 32-bit pattern
	typedef struct packed {
		logic signed [31:0] t1, t2, t3;
		logic signed [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [31:0] h1, h2, h3, h4, h5, h6;
	} cal_t;

	// fields handed from the front pipeline through the divider
	typedef struct packed {
		logic signed [17:0] temp;
		logic [13:0]        hum;
		logic               pvalid;
		logic               post_shift;
	} side_t;

endpackage

FILE: hdl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw pressure, temperature and humidity readings.
// ----------------------------------------------------------------------------
// Pipeline: 11 front stages, 32 divider stages and 3 back stages,
//   the last back stage being the output register.
// Throughput: one beat per cycle; the whole pipe holds while a result waits.
// Depth is set by the pressure divide, one quotient bit per stage.
// Reset clears all valid bits and calibration registers to zero.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [esc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [19:0]                    raw_pressure,
	input  logic [19:0]                    raw_temperature,
	input  logic [15:0]                    raw_humidity,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [17:0]             temperature_centi,
	output logic [13:0]                    humidity_centi,
	output logic [23:0]                    pressure_pa,
	output logic                           pressure_valid
);
	import esc_pkg::*;

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_last_q;
	logic [31:0] cal_hum_a_q;
	logic [39:0] cal_hum_b_q;

	cal_t  cal;
	logic  en;
	logic  f_vld, d_vld;
	logic [DIV_W-1:0] f_num, f_den, d_quo;
	side_t f_side, d_side;

	// Configuration writes are always taken; unknown indexes drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q       <= '0;
			cal_press_a_q    <= '0;
			cal_press_b_q    <= '0;
			cal_press_last_q <= '0;
			cal_hum_a_q      <= '0;
			cal_hum_b_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_CAL_TEMP:       cal_temp_q       <= cfg_data[47:0];
				REG_CAL_PRESS_A:    cal_press_a_q    <= cfg_data;
				REG_CAL_PRESS_B:    cal_press_b_q    <= cfg_data;
				REG_CAL_PRESS_LAST: cal_press_last_q <= cfg_data[15:0];
				REG_CAL_HUM_A:      cal_hum_a_q      <= cfg_data[31:0];
				REG_CAL_HUM_B:      cal_hum_b_q      <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	// Split the calibration words; T1, P1, H1 and H3 are unsigned.
	always_comb begin
		cal.t1 = {16'd0, cal_temp_q[15:0]};
		cal.t2 = {{16{cal_temp_q[31]}}, cal_temp_q[31:16]};
		cal.t3 = {{16{cal_temp_q[47]}}, cal_temp_q[47:32]};
		cal.p1 = {16'd0, cal_press_a_q[15:0]};
		cal.p2 = {{16{cal_press_a_q[31]}}, cal_press_a_q[31:16]};
		cal.p3 = {{16{cal_press_a_q[47]}}, cal_press_a_q[47:32]};
		cal.p4 = {{16{cal_press_a_q[63]}}, cal_press_a_q[63:48]};
		cal.p5 = {{16{cal_press_b_q[15]}}, cal_press_b_q[15:0]};
		cal.p6 = {{16{cal_press_b_q[31]}}, cal_press_b_q[31:16]};
		cal.p7 = {{16{cal_press_b_q[47]}}, cal_press_b_q[47:32]};
		cal.p8 = {{16{cal_press_b_q[63]}}, cal_press_b_q[63:48]};
		cal.p9 = {{16{cal_press_last_q[15]}}, cal_press_last_q};
		cal.h1 = {24'd0, cal_hum_a_q[7:0]};
		cal.h2 = {{16{cal_hum_a_q[23]}}, cal_hum_a_q[23:8]};
		cal.h3 = {24'd0, cal_hum_a_q[31:24]};
		cal.h4 = {{16{cal_hum_b_q[15]}}, cal_hum_b_q[15:0]};
		cal.h5 = {{16{cal_hum_b_q[31]}}, cal_hum_b_q[31:16]};
		cal.h6 = {{24{cal_hum_b_q[39]}}, cal_hum_b_q[39:32]};
	end

	// Advance every stage together unless a finished result is held.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	esc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_vld          (in_valid),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.cal             (cal),
		.out_vld         (f_vld),
		.num             (f_num),
		.den             (f_den),
		.side            (f_side)
	);

	// A zero divisor gives a don't-care quotient; the back end zeroes it.
	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.num      (f_num),
		.den      (f_den),
		.side_in  (f_side),
		.out_vld  (d_vld),
		.quo      (d_quo),
		.side_out (d_side)
	);

	esc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.in_vld            (d_vld),
		.quo               (d_quo),
		.side_in           (d_side),
		.cal               (cal),
		.out_vld           (out_valid),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.pressure_pa       (pressure_pa),
		.pressure_valid    (pressure_valid)
	);

endmodule

FILE: hdl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module esc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [esc_pkg::DIV_W-1:0]   num,
	input  logic [esc_pkg::DIV_W-1:0]   den,
	input  esc_pkg::side_t              side_in,
	output logic                        out_vld,
	output logic [esc_pkg::DIV_W-1:0]   quo,
	output esc_pkg::side_t              side_out
);
	import esc_pkg::*;

	localparam int unsigned N = DIV_W;

	logic [N-1:0] rem_s  [N];
	logic [N-1:0] num_s  [N];
	logic [N-1:0] quo_s  [N];
	logic [N-1:0] den_s  [N];
	side_t        side_s [N];
	logic [N-1:0] vld_s;

	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [N-1:0] rem_i, num_i, quo_i, den_i;
		side_t        side_i;
		logic         vld_i;
		logic [N:0]   cand, diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign num_i  = num;
			assign quo_i  = '0;
			assign den_i  = den;
			assign side_i = side_in;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign num_i  = num_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign cand = {rem_i, num_i[N-1]};
		assign diff = cand - {1'b0, den_i};
		assign ge   = (cand >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[N-1:0] : cand[N-1:0];
				num_s[k]  <= {num_i[N-2:0], 1'b0};
				quo_s[k]  <= {quo_i[N-2:0], ge};
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign quo      = quo_s[N-1];
	assign side_out = side_s[N-1];

endmodule

FILE: hdl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Temperature, humidity and pressure dividend/divisor in eleven stages.
// ----------------------------------------------------------------------------
module esc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [19:0]               raw_pressure,
	input  logic [19:0]               raw_temperature,
	input  logic [15:0]               raw_humidity,
	input  esc_pkg::cal_t             cal,
	output logic                      out_vld,
	output logic [esc_pkg::DIV_W-1:0] num,
	output logic [esc_pkg::DIV_W-1:0] den,
	output esc_pkg::side_t            side
);
	import esc_pkg::*;

	logic [10:0] vld_s;

	logic signed [31:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6;
	logic signed [31:0] ah_s1, ah_s2, ah_s3, ah_s4;
	logic signed [31:0] ta_s1, dd_s1, ta_s2, tb_s2, tf_s3;
	logic signed [17:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic signed [17:0] temp_s11;
	logic signed [31:0] m1_s4, m2_s4, m3_s4, ss_s4, ap5_s4, ap2_s4;
	logic signed [31:0] ha_s5, hq_s5, pb_s5, pc_s5, ap5_s5, ap2_s5;
	logic signed [31:0] ha_s6, hb0_s6, pbb_s6, pa2_s6;
	logic signed [31:0] ha_s7, hb_s7, pa3_s7, pn_s7;
	logic signed [31:0] hx_s8, pdiv_s8, pr_s8;
	logic signed [31:0] hx_s9, hss_s9, hx_s10, ht_s10;
	logic [31:0]        num_s9, num_s10, num_s11;
	logic [31:0]        den_s9, den_s10, den_s11;
	logic               pv_s9, pv_s10, pv_s11, sh_s9, sh_s10, sh_s11;
	logic [13:0]        hum_s11;

	logic signed [31:0] at32, d0, t5, hx0, px0, ps0, hx_fin, hx_clip;
	logic signed [31:0] tmp_a0, temp_full, hs;
	logic [31:0]        hum_w;

	always_comb begin
		at32      = {12'd0, raw_temperature};
		tmp_a0    = (at32 >>> 3) - (cal.t1 <<< 1);
		d0        = (at32 >>> 4) - cal.t1;
		temp_full = (tf_s3 * 32'sd5 + 32'sd128) >>> 8;
		hx0       = tf_s3 - 32'sd76800;
		px0       = (tf_s3 >>> 1) - 32'sd64000;
		ps0       = px0 >>> 2;
		hs        = hx_s8 >>> 15;
		t5        = ht_s10 >>> 4;
		hx_fin    = hx_s10 - t5;
		// clamp to 0..419430400 before scaling
		if (hx_fin[31])
			hx_clip = '0;
		else if (hx_fin > 32'sd419430400)
			hx_clip = 32'sd419430400;
		else
			hx_clip = hx_fin;
		hum_w = (({12'd0, hx_clip[31:12]}) * 32'd100) >> 10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[9:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			ap_s1 <= {12'd0, raw_pressure};
			ah_s1 <= {16'd0, raw_humidity};
			ta_s1 <= tmp_a0 * cal.t2;
			dd_s1 <= d0 * d0;
			// stage 2
			ap_s2 <= ap_s1;
			ah_s2 <= ah_s1;
			ta_s2 <= ta_s1 >>> 11;
			tb_s2 <= (dd_s1 >>> 12) * cal.t3;
			// stage 3
			ap_s3 <= ap_s2;
			ah_s3 <= ah_s2;
			tf_s3 <= ta_s2 + (tb_s2 >>> 14);
			// stage 4
			ap_s4   <= ap_s3;
			ah_s4   <= ah_s3;
			temp_s4 <= temp_full[17:0];
			m1_s4   <= cal.h5 * hx0;
			m2_s4   <= hx0 * cal.h6;
			m3_s4   <= hx0 * cal.h3;
			ss_s4   <= ps0 * ps0;
			ap5_s4  <= px0 * cal.p5;
			ap2_s4  <= cal.p2 * px0;
			// stage 5
			ap_s5   <= ap_s4;
			temp_s5 <= temp_s4;
			ha_s5   <= ((ah_s4 <<< 14) - (cal.h4 <<< 20) - m1_s4 + 32'sd16384) >>> 15;
			hq_s5   <= (m2_s4 >>> 10) * ((m3_s4 >>> 11) + 32'sd32768);
			pb_s5   <= (ss_s4 >>> 11) * cal.p6;
			pc_s5   <= cal.p3 * (ss_s4 >>> 13);
			ap5_s5  <= ap5_s4;
			ap2_s5  <= ap2_s4;
			// stage 6
			ap_s6   <= ap_s5;
			temp_s6 <= temp_s5;
			ha_s6   <= ha_s5;
			hb0_s6  <= ((hq_s5 >>> 10) + 32'sd2097152) * cal.h2;
			pbb_s6  <= ((pb_s5 + (ap5_s5 <<< 1)) >>> 2) + (cal.p4 <<< 16);
			pa2_s6  <= ((pc_s5 >>> 3) + (ap2_s5 >>> 1)) >>> 18;
			// stage 7
			temp_s7 <= temp_s6;
			ha_s7   <= ha_s6;
			hb_s7   <= (hb0_s6 + 32'sd8192) >>> 14;
			pa3_s7  <= (32'sd32768 + pa2_s6) * cal.p1;
			pn_s7   <= (32'sd1048576 - ap_s6) - (pbb_s6 >>> 12);
			// stage 8
			temp_s8 <= temp_s7;
			hx_s8   <= ha_s7 * hb_s7;
			pdiv_s8 <= pa3_s7 >>> 15;
			pr_s8   <= pn_s7 * 32'sd3125;
			// stage 9: pick pre- or post-shift of the dividend
			temp_s9 <= temp_s8;
			hx_s9   <= hx_s8;
			hss_s9  <= hs * hs;
			sh_s9   <= pr_s8[31];
			num_s9  <= pr_s8[31] ? pr_s8 : (pr_s8 <<< 1);
			den_s9  <= pdiv_s8;
			pv_s9   <= (pdiv_s8 != '0);
			// stage 10
			temp_s10 <= temp_s9;
			hx_s10   <= hx_s9;
			ht_s10   <= (hss_s9 >>> 7) * cal.h1;
			sh_s10   <= sh_s9;
			num_s10  <= num_s9;
			den_s10  <= den_s9;
			pv_s10   <= pv_s9;
			// stage 11
			temp_s11 <= temp_s10;
			hum_s11  <= hum_w[13:0];
			sh_s11   <= sh_s10;
			num_s11  <= num_s10;
			den_s11  <= den_s10;
			pv_s11   <= pv_s10;
		end
	end

	assign out_vld         = vld_s[10];
	assign num             = num_s11;
	assign den             = den_s11;
	assign side.temp       = temp_s11;
	assign side.hum        = hum_s11;
	assign side.pvalid     = pv_s11;
	assign side.post_shift = sh_s11;

endmodule

FILE: hdl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Final pressure correction after the divide; last stage is the output register.
// ----------------------------------------------------------------------------
module esc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [esc_pkg::DIV_W-1:0] quo,
	input  esc_pkg::side_t            side_in,
	input  esc_pkg::cal_t             cal,
	output logic                      out_vld,
	output logic signed [17:0]        temperature_centi,
	output logic [13:0]               humidity_centi,
	output logic [23:0]               pressure_pa,
	output logic                      pressure_valid
);
	import esc_pkg::*;

	logic [2:0]         vld_s;
	logic [31:0]        ps_s1, ss_s1, ps_s2;
	logic signed [31:0] pb_s1, pa_s2, pb_s2;
	side_t              side_s1, side_s2;
	logic [17:0]        temp_s3;
	logic [13:0]        hum_s3;
	logic [23:0]        press_s3;
	logic               pv_s3;

	logic [31:0]        press0, sdiv8, quart, fin;

	always_comb begin
		press0 = side_in.post_shift ? (quo << 1) : quo;
		sdiv8  = press0 >> 3;
		quart  = press0 >> 2;
		// keep the correction term signed so the shift is arithmetic
		fin    = ps_s2 + $unsigned((pa_s2 + pb_s2 + cal.p7) >>> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ps_s1    <= press0;
			ss_s1    <= sdiv8 * sdiv8;
			pb_s1    <= $signed(quart) * cal.p8;
			side_s1  <= side_in;
			ps_s2    <= ps_s1;
			pa_s2    <= (cal.p9 * $signed(ss_s1 >> 13)) >>> 12;
			pb_s2    <= pb_s1 >>> 13;
			side_s2  <= side_s1;
			temp_s3  <= side_s2.temp;
			hum_s3   <= side_s2.hum;
			press_s3 <= side_s2.pvalid ? fin[23:0] : '0;
			pv_s3    <= side_s2.pvalid;
		end
	end

	assign out_vld           = vld_s[2];
	assign temperature_centi = temp_s3;
	assign humidity_centi    = hum_s3;
	assign pressure_pa       = press_s3;
	assign pressure_valid    = pv_s3;

endmodule
